/* sv/rlps_pkg.sv */
// Shared types, constants and helpers for the radial light pixel shader.
// No dependencies; every other file of the block imports this package.
package rlps_pkg;

	localparam int IN_W   = 48;
	localparam int OUT_W  = 32;
	localparam int OFF_W  = 11;
	localparam int CH_W   = 8;
	localparam int D2_W   = 22;
	localparam int ROOT_W = 19;
	localparam int RAD_W  = 10;
	localparam int Q_W    = 17;
	localparam int CFG_IDX_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS = 8'd0,
		REG_RED    = 8'd1,
		REG_GREEN  = 8'd2,
		REG_BLUE   = 8'd3
	} cfg_reg_t;

	// Per-pixel data that rides alongside the distance pipeline.
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            in_circle;
		logic            center;
	} side_t;

	// floor(x / 255) for x up to 255 * 255.
	function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
		logic [16:0] xp;
		logic [16:0] sum;
		xp  = {1'b0, x} + 17'd1;
		sum = xp + {8'd0, xp[16:8]};
		return sum[15:8];
	endfunction

endpackage

/* sv/radial_light_pixel_shade.sv */
// Top level of the radial point-light pixel shader.
// Depends on rlps_pkg, rlps_sqrt, rlps_div and rlps_pow.
//
// Usage: each pixel enters as one transfer on the s_axis group. tdata holds,
// from bit 0 up, offset_x (11 bits, signed), offset_y (11 bits, signed),
// scene red, green and blue (8 bits each). Each pixel yields exactly one
// transfer on the m_axis group carrying the lit red, green, blue channels and
// the falloff level. Pixels are independent, so one pixel is taken every
// clock cycle as long as the receiver keeps up.
// Each pixel passes through registered steps in order: squaring and range
// test, square root (up to four root bits a stage), division (up to four
// quotient bits a stage), the power table read and level scaling, and the
// two color multiply and divide-by-255 steps.
// The light registers are written through cfg_we / cfg_index / cfg_data and
// are read live by the pipeline, so they should only change while no pixel
// is in flight. Reset clears all valid bits and loads radius 16 and a white
// light. When the receiver stalls, the whole pipeline holds: s_axis_tready
// drops in the same cycle, and nothing is lost or repeated.
module radial_light_pixel_shade #(
	parameter int POW_TABLE_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rlps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rlps_pkg::RAD_W-1:0]     cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// offset_x, offset_y, scene_red, scene_green, scene_blue, zero fill
	input  logic [rlps_pkg::IN_W-1:0]      s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_red, out_green, out_blue, falloff_level
	output logic [rlps_pkg::OUT_W-1:0]     m_axis_tdata
);
	import rlps_pkg::*;

	logic [RAD_W-1:0] radius_q;
	logic [CH_W-1:0]  light_red_q, light_green_q, light_blue_q;
	logic             en;

	// Stalls only when the output register holds a transfer not yet taken.
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= RAD_W'(16);
			light_red_q   <= 8'd255;
			light_green_q <= 8'd255;
			light_blue_q  <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RADIUS: radius_q      <= cfg_data;
				REG_RED:    light_red_q   <= cfg_data[CH_W-1:0];
				REG_GREEN:  light_green_q <= cfg_data[CH_W-1:0];
				REG_BLUE:   light_blue_q  <= cfg_data[CH_W-1:0];
				default:    ;
			endcase
		end
	end

	// Stage 1: magnitudes and squares.
	logic signed [OFF_W-1:0] off_x, off_y;
	logic [OFF_W-1:0]        ax, ay;
	logic [2*OFF_W-1:0]      sqx_s1, sqy_s1;
	side_t                   side_in, side_s1, side_mid, side_s2;
	logic                    vld_s1, vld_s2;
	logic [D2_W-1:0]         d2, d2_s2;
	logic [2*RAD_W-1:0]      rr;

	assign off_x = s_axis_tdata[10:0];
	assign off_y = s_axis_tdata[21:11];
	assign ax    = off_x[OFF_W-1] ? OFF_W'(-off_x) : off_x;
	assign ay    = off_y[OFF_W-1] ? OFF_W'(-off_y) : off_y;

	always_comb begin
		side_in        = '0;
		side_in.red    = s_axis_tdata[29:22];
		side_in.green  = s_axis_tdata[37:30];
		side_in.blue   = s_axis_tdata[45:38];
	end

	assign d2 = D2_W'({1'b0, sqx_s1} + {1'b0, sqy_s1});
	assign rr = radius_q * radius_q;

	// Circle test and center flag join the side data before stage 2.
	always_comb begin
		side_mid           = side_s1;
		side_mid.in_circle = (radius_q != '0) && ({1'b0, d2} <= {3'b0, rr});
		side_mid.center    = (d2 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 2: squared distance, circle test; the center inside is full level.
	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1  <= ax * ax;
			sqy_s1  <= ay * ay;
			side_s1 <= side_in;
			d2_s2   <= d2;
			side_s2 <= side_mid;
		end
	end

	logic              sq_valid, dv_valid, pw_valid;
	logic [ROOT_W-1:0] root;
	logic [Q_W-1:0]    quot;
	logic [CH_W-1:0]   level;
	side_t             sq_side, dv_side, pw_side;

	rlps_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s2), .d2(d2_s2), .in_side(side_s2),
		.out_valid(sq_valid), .root(root), .out_side(sq_side)
	);

	rlps_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .radius(radius_q),
		.in_valid(sq_valid), .root(root), .in_side(sq_side),
		.out_valid(dv_valid), .quot(quot), .out_side(dv_side)
	);

	rlps_pow #(.POW_TABLE_BITS(POW_TABLE_BITS)) u_pow (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(dv_valid), .quot(quot), .in_side(dv_side),
		.out_valid(pw_valid), .level(level), .out_side(pw_side)
	);

	// Color path: scale by level, divide by 255, scale by light, divide by 255.
	logic [15:0]     pr_c1, pg_c1, pb_c1, pr_c3, pg_c3, pb_c3;
	logic [CH_W-1:0] ar_c2, ag_c2, ab_c2, lev_c1, lev_c2, lev_c3;
	logic            vld_c1, vld_c2, vld_c3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c1        <= 1'b0;
			vld_c2        <= 1'b0;
			vld_c3        <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			vld_c1        <= pw_valid;
			vld_c2        <= vld_c1;
			vld_c3        <= vld_c2;
			m_axis_tvalid <= vld_c3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_c1  <= pw_side.red   * level;
			pg_c1  <= pw_side.green * level;
			pb_c1  <= pw_side.blue  * level;
			lev_c1 <= level;
			ar_c2  <= div255(pr_c1);
			ag_c2  <= div255(pg_c1);
			ab_c2  <= div255(pb_c1);
			lev_c2 <= lev_c1;
			pr_c3  <= ar_c2 * light_red_q;
			pg_c3  <= ag_c2 * light_green_q;
			pb_c3  <= ab_c2 * light_blue_q;
			lev_c3 <= lev_c2;
			m_axis_tdata <= {lev_c3, div255(pb_c3), div255(pg_c3), div255(pr_c3)};
		end
	end
endmodule

/* sv/rlps_sqrt.sv */
// Pipelined digit-by-digit square root of d2 * 2^16 (distance with 8 fraction bits).
// Depends on rlps_pkg.
module rlps_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [rlps_pkg::D2_W-1:0]   d2,
	input  rlps_pkg::side_t            in_side,
	output logic                       out_valid,
	output logic [rlps_pkg::ROOT_W-1:0] root,
	output rlps_pkg::side_t            out_side
);
	import rlps_pkg::*;

	localparam int PER = 4;
	localparam int NS  = (ROOT_W + PER - 1) / PER;
	localparam int REM_W = ROOT_W + 2;

	logic [ROOT_W-1:0] root_s [NS+1];
	logic [REM_W-1:0]  rem_s  [NS+1];
	logic [D2_W-1:0]   d2_s   [NS+1];
	side_t             side_s [NS+1];
	logic              vld_s  [NS+1];

	assign root_s[0] = '0;
	assign rem_s[0]  = '0;
	assign d2_s[0]   = d2;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_valid;

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [ROOT_W-1:0] root_n;
		logic [REM_W-1:0]  rem_n;

		always_comb begin
			int k;
			int b;
			logic [1:0]       pair;
			logic [REM_W-1:0] trial;
			root_n = root_s[g];
			rem_n  = rem_s[g];
			for (int j = 0; j < PER; j++) begin
				k = ROOT_W - 1 - (g * PER + j);
				if (k >= 0) begin
					b    = (k >= 8) ? 2 * (k - 8) : 0;
					pair = (k >= 8) ? d2_s[g][b +: 2] : 2'b00;
					rem_n = {rem_n[REM_W-3:0], pair};
					trial = {root_n, 2'b01};
					if (rem_n >= trial) begin
						rem_n  = rem_n - trial;
						root_n = {root_n[ROOT_W-2:0], 1'b1};
					end else begin
						root_n = {root_n[ROOT_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[g+1] <= root_n;
				rem_s[g+1]  <= rem_n;
				d2_s[g+1]   <= d2_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_valid = vld_s[NS];
	assign root      = root_s[NS];
	assign out_side  = side_s[NS];
endmodule

/* sv/rlps_div.sv */
// Pipelined restoring divider: q = floor(s * 2^8 / radius), 17 quotient bits.
// Depends on rlps_pkg.
module rlps_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [rlps_pkg::RAD_W-1:0]  radius,
	input  logic                        in_valid,
	input  logic [rlps_pkg::ROOT_W-1:0] root,
	input  rlps_pkg::side_t             in_side,
	output logic                        out_valid,
	output logic [rlps_pkg::Q_W-1:0]    quot,
	output rlps_pkg::side_t             out_side
);
	import rlps_pkg::*;

	localparam int PER = 4;
	localparam int NS  = (Q_W + PER - 1) / PER;
	localparam int R_W = RAD_W + 1;

	logic [Q_W-1:0]    q_s    [NS+1];
	logic [R_W-1:0]    rem_s  [NS+1];
	logic [ROOT_W-1:0] s_s    [NS+1];
	side_t             side_s [NS+1];
	logic              vld_s  [NS+1];

	// Inside the circle s <= 256 * radius, so the upper part is below radius.
	assign q_s[0]    = '0;
	assign rem_s[0]  = {1'b0, root[ROOT_W-1 -: RAD_W]};
	assign s_s[0]    = root;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_valid;

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [Q_W-1:0] q_n;
		logic [R_W-1:0] rem_n;

		always_comb begin
			int k;
			int b;
			logic nb;
			q_n   = q_s[g];
			rem_n = rem_s[g];
			for (int j = 0; j < PER; j++) begin
				k = Q_W - 1 - (g * PER + j);
				if (k >= 0) begin
					b  = (k >= 8) ? k - 8 : 0;
					nb = (k >= 8) ? s_s[g][b] : 1'b0;
					rem_n = {rem_n[R_W-2:0], nb};
					if (rem_n >= {1'b0, radius}) begin
						rem_n = rem_n - {1'b0, radius};
						q_n   = {q_n[Q_W-2:0], 1'b1};
					end else begin
						q_n   = {q_n[Q_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[g+1]    <= q_n;
				rem_s[g+1]  <= rem_n;
				s_s[g+1]    <= s_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_valid = vld_s[NS];
	assign quot      = q_s[NS];
	assign out_side  = side_s[NS];
endmodule

/* sv/rlps_pow.sv */
// Falloff curve: t = 1 - q, power table lookup of t^1.8, scaling to a 0..255 level.
// Depends on rlps_pkg; the table is computed at elaboration from POW_TABLE_BITS.
module rlps_pow #(
	parameter int POW_TABLE_BITS = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [rlps_pkg::Q_W-1:0] quot,
	input  rlps_pkg::side_t          in_side,
	output logic                     out_valid,
	output logic [rlps_pkg::CH_W-1:0] level,
	output rlps_pkg::side_t          out_side
);
	import rlps_pkg::*;

	localparam int POW_N = 1 << POW_TABLE_BITS;
	localparam int WW    = 200;

	typedef logic [15:0] rom_t [POW_N];

	// Largest v with v^5 * 2^(9B) <= i^9 * 2^80, found by bitwise search.
	function automatic logic [15:0] pow_entry(input int i);
		logic [15:0]   v;
		logic [15:0]   cand;
		logic [WW-1:0] lhs;
		logic [WW-1:0] rhs;
		v   = '0;
		rhs = WW'(1);
		for (int n = 0; n < 9; n++) rhs = rhs * WW'(i);
		rhs = rhs << 80;
		for (int bt = 15; bt >= 0; bt--) begin
			cand = v | (16'd1 << bt);
			lhs  = WW'(1);
			for (int n = 0; n < 5; n++) lhs = lhs * WW'(cand);
			lhs = lhs << (9 * POW_TABLE_BITS);
			if (lhs <= rhs) v = cand;
		end
		return v;
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < POW_N; i++) r[i] = pow_entry(i);
		return r;
	endfunction

	localparam rom_t POW_ROM = build_rom();

	logic [Q_W-1:0]            t_val;
	logic [POW_TABLE_BITS-1:0] idx;
	logic [15:0]               p_s1;
	side_t                     side_s1;
	logic                      vld_s1;
	logic [23:0]               scaled;

	assign t_val = quot[Q_W-1] ? '0 : Q_W'(17'h10000) - quot;
	assign idx   = t_val[15 -: POW_TABLE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= POW_ROM[idx];
			side_s1 <= in_side;
		end
	end

	assign scaled = {8'd0, p_s1} * 24'd255;

	always_ff @(posedge clk) begin
		if (en) begin
			out_side <= side_s1;
			if (!side_s1.in_circle) begin
				level <= '0;
			end else if (side_s1.center) begin
				level <= 8'd255;
			end else begin
				level <= scaled[23:16];
			end
		end
	end
endmodule

/* sv/rlps_checker.sv */
// Port-level checker for the radial light pixel shader, bound to the top level.
// Depends on rlps_pkg and radial_light_pixel_shade.
module rlps_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [rlps_pkg::OUT_W-1:0]     m_axis_tdata
);
	import rlps_pkg::*;

	// An empty or draining output register never holds off the source.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
		else $error("input stalled while output free");

	// A zero level darkens every channel.
	a_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[31:24] == 8'd0) |-> (m_axis_tdata[23:0] == 24'd0))
		else $error("lit color outside the light");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled output transfer changed");

	// Output can only appear long after reset: the pipeline is 18 deep.
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("output valid right after reset");
endmodule

bind radial_light_pixel_shade rlps_checker u_rlps_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

/* tb/sv/radial_light_pixel_shade_test.sv */
// Self-checking testbench for the radial light pixel shader.
// Depends on rlps_pkg and radial_light_pixel_shade; the predictor is built in here.
module radial_light_pixel_shade_test;
	import rlps_pkg::*;

	localparam int CURVE_BITS = 10;
	localparam int CURVE_SIZE = 1 << CURVE_BITS;
	// An index past the last light register; the block must ignore it.
	localparam logic [CFG_IDX_W-1:0] UNUSED_REG_INDEX = 8'd9;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic signed [OFF_W-1:0] off_x;
		logic signed [OFF_W-1:0] off_y;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} scene_pixel_t;

	typedef struct {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] level;
	} lit_pixel_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RAD_W-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;

	radial_light_pixel_shade DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Shadow copy of the light registers, updated by every write we issue.
	logic [RAD_W-1:0] light_radius;
	logic [CH_W-1:0] light_red, light_green, light_blue;

	// Q0.16 samples of t^1.8, found exactly in integers.
	int unsigned falloff_curve [CURVE_SIZE];

	scene_pixel_t pixel_backlog[$];
	lit_pixel_t lit_expected[$];

	int errors = 0;
	int pixels_sent = 0;
	int pixels_lit = 0;
	int pixels_dark = 0;
	bit pacing_on = 1'b1;
	bit in_taken = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;
	int recv_hold = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// v^5 * 2^(9*B) <= i^9 * 2^80, with B = 10 so the left side gets a shift of 10.
	function automatic bit curve_fits(int unsigned i, int unsigned v);
		logic [127:0] lhs;
		logic [127:0] rhs;
		lhs = 128'd1;
		rhs = 128'd1;
		for (int n = 0; n < 5; n++) lhs = lhs * v;
		for (int n = 0; n < 9; n++) rhs = rhs * i;
		lhs = lhs << (9 * CURVE_BITS - 80);
		return lhs <= rhs;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 40;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic lit_pixel_t predict_shade(scene_pixel_t px);
		lit_pixel_t lp;
		longint unsigned ax, ay, d2, r, lvl, s, q, t, a;
		logic [CURVE_BITS-1:0] ci;
		ax = (px.off_x < 0) ? -longint'(px.off_x) : longint'(px.off_x);
		ay = (px.off_y < 0) ? -longint'(px.off_y) : longint'(px.off_y);
		d2 = ax * ax + ay * ay;
		r = light_radius;
		lvl = 0;
		if (r != 0 && d2 <= r * r) begin
			if (d2 == 0) begin
				// At the centre the power is taken as exactly one.
				lvl = 255;
			end else begin
				s = root_floor(d2 << 16);
				q = (s << 8) / r;
				t = (q >= 65536) ? 0 : 65536 - q;
				ci = CURVE_BITS'(t >> (16 - CURVE_BITS));
				lvl = (255 * falloff_curve[ci]) >> 16;
			end
		end
		a = (px.red * lvl) / 255;
		lp.red = CH_W'((a * light_red) / 255);
		a = (px.green * lvl) / 255;
		lp.green = CH_W'((a * light_green) / 255);
		a = (px.blue * lvl) / 255;
		lp.blue = CH_W'((a * light_blue) / 255);
		lp.level = CH_W'(lvl);
		return lp;
	endfunction

	// Pixel sender: a new transfer is offered only once the previous one has gone.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid = 1'b0;
			end else if (pixel_backlog.size() > 0) begin
				if (pacing_on && $urandom_range(0, 7) == 0) begin
					// Idle burst, counting this one; send_gap holds the rest.
					send_gap = $urandom_range(0, 4);
					s_axis_tvalid = 1'b0;
				end else begin
					scene_pixel_t px;
					px = pixel_backlog.pop_front();
					s_axis_tdata = {2'b00, px.blue, px.green, px.red, px.off_y, px.off_x};
					s_axis_tvalid = 1'b1;
				end
			end else begin
				s_axis_tvalid = 1'b0;
			end
		end
	end

	// Receiver back-pressure: random short stalls plus one long hold,
	// which fills the pipeline and must push back on the input side.
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			recv_hold--;
			m_axis_tready = 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_axis_tready = 1'b0;
		end else if (pacing_on && arst_n && $urandom_range(0, 7) == 0) begin
			recv_gap = $urandom_range(0, 4);
			m_axis_tready = 1'b0;
		end else begin
			m_axis_tready = 1'b1;
		end
	end

	// Input monitor: every accepted pixel gets its expected shade right away.
	// The light registers only change while nothing is in flight.
	always @(posedge clk) begin
		in_taken = s_axis_tvalid && s_axis_tready;
		if (in_taken) begin
			scene_pixel_t px;
			lit_pixel_t lp;
			px.off_x = s_axis_tdata[10:0];
			px.off_y = s_axis_tdata[21:11];
			px.red = s_axis_tdata[29:22];
			px.green = s_axis_tdata[37:30];
			px.blue = s_axis_tdata[45:38];
			lp = predict_shade(px);
			lit_expected.insert(lit_expected.size(), lp);
			pixels_sent++;
			if (lp.level != 0) pixels_lit++;
			else pixels_dark++;
		end
	end

	// Output monitor: each transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			lit_pixel_t want;
			lit_pixel_t got;
			got.red = m_axis_tdata[7:0];
			got.green = m_axis_tdata[15:8];
			got.blue = m_axis_tdata[23:16];
			got.level = m_axis_tdata[31:24];
			if (lit_expected.size() == 0) begin
				errors++;
				$display("%0t: expected no transfer, actual output %h", $time, m_axis_tdata);
			end else begin
				want = lit_expected.pop_front();
				if (got.red !== want.red) begin
					errors++;
					$display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
				end
				if (got.green !== want.green) begin
					errors++;
					$display("%0t: green expected %0d actual %0d", $time, want.green,
						got.green);
				end
				if (got.blue !== want.blue) begin
					errors++;
					$display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
				end
				if (got.level !== want.level) begin
					errors++;
					$display("%0t: falloff expected %0d actual %0d", $time, want.level,
						got.level);
				end
			end
		end
	end

	task automatic write_light(logic [CFG_IDX_W-1:0] idx, logic [RAD_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		case (idx)
			REG_RADIUS: light_radius = val;
			REG_RED: light_red = val[7:0];
			REG_GREEN: light_green = val[7:0];
			REG_BLUE: light_blue = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic queue_pixel(int x, int y, int r, int g, int b);
		scene_pixel_t px;
		px.off_x = OFF_W'(x);
		px.off_y = OFF_W'(y);
		px.red = CH_W'(r);
		px.green = CH_W'(g);
		px.blue = CH_W'(b);
		pixel_backlog.insert(pixel_backlog.size(), px);
	endtask

	// Mostly offsets near the circle so the falloff curve is well exercised,
	// the rest anywhere in the full signed range.
	task automatic queue_random_pixels(int count);
		int reach;
		for (int n = 0; n < count; n++) begin
			reach = (light_radius > 1000) ? 1023 : light_radius + 2;
			if ($urandom_range(0, 3) == 0)
				queue_pixel($urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
			else
				queue_pixel(int'($urandom_range(0, 2 * reach)) - reach,
					int'($urandom_range(0, 2 * reach)) - reach,
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
		end
	endtask

	// Waits until the backlog is out, the last offer is taken and every
	// result is back, then gives the pipeline time to settle before any
	// register write.
	task automatic drain;
		while (pixel_backlog.size() > 0 || s_axis_tvalid || lit_expected.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned v;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_RADIUS;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		light_radius = 10'd16;
		light_red = 8'd255;
		light_green = 8'd255;
		light_blue = 8'd255;

		v = 0;
		for (int i = 0; i < CURVE_SIZE; i++) begin
			while (v < 65535 && curve_fits(i, v + 1)) v++;
			falloff_curve[i] = v;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pixels at reset settings: centre, rim, just outside,
		// corners of the offset range and extreme colors.
		queue_pixel(0, 0, 255, 255, 255);
		queue_pixel(0, 0, 0, 0, 0);
		queue_pixel(16, 0, 255, 255, 255);
		queue_pixel(0, -16, 255, 128, 1);
		queue_pixel(17, 0, 255, 255, 255);
		queue_pixel(-12, 9, 200, 100, 50);
		queue_pixel(12, 12, 255, 255, 255);
		queue_pixel(1, 0, 255, 0, 255);
		queue_pixel(-1, -1, 1, 254, 128);
		queue_pixel(-1024, -1024, 255, 255, 255);
		queue_pixel(1023, 1023, 255, 255, 255);
		queue_pixel(-1024, 0, 170, 85, 255);
		queue_pixel(0, 1023, 255, 255, 255);
		queue_pixel(8, -8, 255, 255, 255);
		queue_pixel(-15, 5, 255, 255, 255);
		queue_pixel(3, 4, 100, 200, 255);
		drain();

		// Largest radius with a white light; a long receiver hold here.
		write_light(REG_RADIUS, 10'd1023);
		write_light(REG_RED, 10'd255);
		write_light(REG_GREEN, 10'd255);
		write_light(REG_BLUE, 10'd255);
		queue_pixel(-1023, 0, 255, 255, 255);
		queue_pixel(-1024, 0, 255, 255, 255);
		queue_pixel(723, -723, 255, 255, 255);
		queue_pixel(0, 0, 255, 255, 255);
		recv_hold = 300;
		queue_random_pixels(200);
		drain();

		// Smallest nonzero radius with mixed light colors.
		write_light(REG_RADIUS, 10'd1);
		write_light(REG_RED, 10'd0);
		write_light(REG_GREEN, 10'd128);
		write_light(REG_BLUE, 10'd255);
		queue_pixel(1, 0, 255, 255, 255);
		queue_pixel(1, 1, 255, 255, 255);
		queue_random_pixels(150);
		drain();

		// Zero radius darkens everything, the centre included; a write to an
		// index past the last register must change nothing.
		write_light(REG_RADIUS, 10'd0);
		write_light(UNUSED_REG_INDEX, 10'd5);
		queue_pixel(0, 0, 255, 255, 255);
		queue_random_pixels(100);
		drain();

		// Wide writes to color registers keep only the low byte.
		write_light(REG_RADIUS, 10'd40);
		write_light(REG_RED, 10'h3FF);
		write_light(REG_GREEN, 10'h2AA);
		write_light(REG_BLUE, 10'h155);
		queue_random_pixels(200);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_light(REG_RADIUS, (ph == 4) ? 10'd300 : RAD_W'($urandom_range(1, 200)));
			write_light(REG_RED, RAD_W'($urandom_range(0, 255)));
			write_light(REG_GREEN, RAD_W'($urandom_range(0, 255)));
			write_light(REG_BLUE, RAD_W'($urandom_range(0, 255)));
			if (ph == 4) pacing_on = 1'b0;
			queue_random_pixels(160);
			drain();
		end

		$display("Covered %0d pixels (%0d lit, %0d dark) over radius 0, 1, 1023 and", pixels_sent,
			pixels_lit, pixels_dark);
		$display("random lights, with input and output stalls and a long output hold.");
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

/* filelist.f */
sv/rlps_pkg.sv
sv/rlps_sqrt.sv
sv/rlps_div.sv
sv/rlps_pow.sv
sv/radial_light_pixel_shade.sv
sv/rlps_checker.sv
tb/sv/radial_light_pixel_shade_test.sv
